FILE: src/spc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the segment pearson correlation block
// no dependencies
package spc_pkg;

   localparam int SMP_W  = 16;
   localparam int CNT_W  = 17;
   localparam int SUM_W  = 33;
   localparam int SQ_W   = 48;
   localparam int PROD_W = 32;
   localparam int WIDE_W = 64;
   localparam int DBL_W  = 128;
   localparam int QUO_W  = 31;
   localparam int ROOT_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_CLAMP = 1'b0;
   localparam logic signed [ROOT_W-1:0] CORR_MAX = 16'sd32767;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sx;
      logic signed [SUM_W-1:0] sy;
      logic [SQ_W-1:0]         sxx;
      logic [SQ_W-1:0]         syy;
      logic signed [SQ_W-1:0]  sxy;
   } sums_type;

   typedef struct packed {
      logic valid;
   } hs_type;

endpackage
`default_nettype wire

FILE: src/spc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// channel interfaces for sample pairs and correlation results
// no dependencies
interface spc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] seismic_sample;
   logic signed [15:0] synthetic_sample;
   logic               last_of_segment;
   modport source (output valid, seismic_sample, synthetic_sample, last_of_segment,
                   input ready);
   modport sink (input valid, seismic_sample, synthetic_sample, last_of_segment,
                 output ready);
endinterface

interface spc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] correlation;
   logic               zero_denominator;
   logic [16:0]        segment_length;
   modport source (output valid, correlation, zero_denominator, segment_length,
                   input ready);
   modport sink (input valid, correlation, zero_denominator, segment_length,
                 output ready);
endinterface
`default_nettype wire

FILE: src/segment_pearson_correlation.sv
`timescale 1ns / 1ps
`default_nettype none
// top level of the segment pearson correlation block
// depends on spc_pkg, spc_if, spc_front, spc_queue and spc_back
//
// Sample pairs enter at one per cycle unless the queue is full at a segment end;
// the front end squares and cross-multiplies each pair, adds it into the segment
// sums and, at the last pair of a segment (or when MAX_SEGMENT pairs have arrived),
// hands the sums to a two-entry queue. The back end works out one segment at a time
// on a shared 64 x 64 multiplier that takes one 16-bit digit a cycle: up to eight
// products, then a 31-step long division and a 16-step square root. Long segments
// stream at full rate; a run of short segments is limited by the back end. A
// segment of one pair always reports a zero denominator. clamp_negative (address
// 0, reset 1) forces results that are not positive to zero.
module segment_pearson_correlation #(
   parameter int MAX_SEGMENT = 65536
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   spc_req_if.sink                            req_bus,
   spc_rsp_if.source                          rsp_bus,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [spc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import spc_pkg::*;

   hs_type   push_hs;
   logic     push_ready, q_valid, q_pop;
   sums_type push_data, q_data;
   logic     clamp_ff, clamp_in;

   always_comb begin
      pready = 1'b1;
      prdata = (paddr[2] == CSR_IDX_CLAMP) ? {31'b0, clamp_ff} : 32'b0;
      clamp_in = clamp_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_IDX_CLAMP) begin
         clamp_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= 1'b1;
      end else begin
         clamp_ff <= clamp_in;
      end
   end

   spc_front #(.MAX_SEGMENT(MAX_SEGMENT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_hs    (push_hs),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   spc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_hs    (push_hs),
      .wr_data  (push_data),
      .wr_ready (push_ready),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  (q_data)
   );

   spc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .clamp_negative (clamp_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_data         (q_data),
      .rsp            (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: src/spc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// front end: per-sample products and segment accumulation
// depends on spc_pkg and spc_if
module spc_front #(
   parameter int MAX_SEGMENT = 65536
) (
   input  wire logic         clock,
   input  wire logic         reset,
   spc_req_if.sink           req,
   output spc_pkg::hs_type   push_hs,
   input  wire logic         push_ready,
   output spc_pkg::sums_type push_data
);
   import spc_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff, s1_last_in;
   logic signed [SMP_W-1:0]  s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic [PROD_W-1:0]        s1_xx_ff, s1_xx_in, s1_yy_ff, s1_yy_in;
   logic signed [PROD_W-1:0] s1_xy_ff, s1_xy_in;
   sums_type                 acc_ff, acc_in, acc_next;
   logic                     s1_end, s1_adv, take;
   logic [CNT_W-1:0]         cnt_next;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENT);

   always_comb begin
      cnt_next = acc_ff.count + 1'b1;
      acc_next.count = cnt_next;
      acc_next.sx  = acc_ff.sx + SUM_W'(s1_x_ff);
      acc_next.sy  = acc_ff.sy + SUM_W'(s1_y_ff);
      acc_next.sxx = acc_ff.sxx + {{(SQ_W-PROD_W){1'b0}}, s1_xx_ff};
      acc_next.syy = acc_ff.syy + {{(SQ_W-PROD_W){1'b0}}, s1_yy_ff};
      acc_next.sxy = acc_ff.sxy + SQ_W'(s1_xy_ff);
      s1_end = s1_last_ff || (cnt_next == MAX_CNT);
      s1_adv = s1_valid_ff && (!s1_end || push_ready);
      req.ready = !s1_valid_ff || s1_adv;
      take = req.valid && req.ready;
      push_hs.valid = s1_valid_ff && s1_end;
      push_data = acc_next;

      acc_in = acc_ff;
      if (s1_adv) begin
         acc_in = s1_end ? '0 : acc_next;
      end
      s1_valid_in = take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_x_in = s1_x_ff;
      s1_y_in = s1_y_ff;
      s1_last_in = s1_last_ff;
      s1_xx_in = s1_xx_ff;
      s1_yy_in = s1_yy_ff;
      s1_xy_in = s1_xy_ff;
      if (take) begin
         s1_x_in = req.seismic_sample;
         s1_y_in = req.synthetic_sample;
         s1_last_in = req.last_of_segment;
         s1_xx_in = PROD_W'(req.seismic_sample * req.seismic_sample);
         s1_yy_in = PROD_W'(req.synthetic_sample * req.synthetic_sample);
         s1_xy_in = req.seismic_sample * req.synthetic_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff <= acc_in;
      end
      s1_x_ff <= s1_x_in;
      s1_y_ff <= s1_y_in;
      s1_last_ff <= s1_last_in;
      s1_xx_ff <= s1_xx_in;
      s1_yy_ff <= s1_yy_in;
      s1_xy_ff <= s1_xy_in;
   end

endmodule
`default_nettype wire

FILE: src/spc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// two-entry queue of finished segment sums between front and back
// depends on spc_pkg
module spc_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  spc_pkg::hs_type   wr_hs,
   input  spc_pkg::sums_type wr_data,
   output logic              wr_ready,
   output logic              rd_valid,
   input  wire logic         rd_pop,
   output spc_pkg::sums_type rd_data
);
   import spc_pkg::*;

   sums_type   ent_ff [2];
   sums_type   ent_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr, rd;

   always_comb begin
      wr_ready = (cnt_ff != 2'd2);
      rd_valid = (cnt_ff != 2'd0);
      rd_data = ent_ff[rp_ff];
      wr = wr_hs.valid && wr_ready;
      rd = rd_pop && rd_valid;
      ent_in = ent_ff;
      if (wr) begin
         ent_in[wp_ff] = wr_data;
      end
      wp_in = wp_ff ^ wr;
      rp_in = rp_ff ^ rd;
      cnt_in = cnt_ff + {1'b0, wr} - {1'b0, rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      ent_ff <= ent_in;
   end

endmodule
`default_nettype wire

FILE: src/spc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// 64 x 64 unsigned multiplier, one 16-bit digit of b per cycle, msb first
// depends on spc_pkg
module spc_mul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [spc_pkg::WIDE_W-1:0] op_a,
   input  wire logic [spc_pkg::WIDE_W-1:0] op_b,
   output logic                           done,
   output logic [spc_pkg::DBL_W-1:0]      product
);
   import spc_pkg::*;

   localparam int DIG_W = 16;
   localparam int NDIG  = WIDE_W / DIG_W;

   logic [WIDE_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [DBL_W-1:0]         acc_ff, acc_in;
   logic [$clog2(NDIG)-1:0]  dig_ff, dig_in;
   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [WIDE_W+DIG_W-1:0]  part;

   always_comb begin
      part = a_ff * b_ff[WIDE_W-1 -: DIG_W];
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      dig_in = dig_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         acc_in = '0;
         dig_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << DIG_W) + DBL_W'(part);
         b_in = b_ff << DIG_W;
         dig_in = dig_ff + 1'b1;
         if (dig_ff == $clog2(NDIG)'(NDIG - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      done = done_ff;
      product = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      dig_ff <= dig_in;
   end

endmodule
`default_nettype wire

FILE: src/spc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// back end: variance terms, long division and square root per segment
// depends on spc_pkg, spc_if and spc_mul
module spc_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         clamp_negative,
   input  wire logic         q_valid,
   output logic              q_pop,
   input  spc_pkg::sums_type q_data,
   spc_rsp_if.source         rsp
);
   import spc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MST  = 3'd1;
   localparam logic [2:0] ST_MWT  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [2:0] OP_NXY = 3'd0;
   localparam logic [2:0] OP_XY  = 3'd1;
   localparam logic [2:0] OP_NXX = 3'd2;
   localparam logic [2:0] OP_XX  = 3'd3;
   localparam logic [2:0] OP_NYY = 3'd4;
   localparam logic [2:0] OP_YY  = 3'd5;
   localparam logic [2:0] OP_AB  = 3'd6;
   localparam logic [2:0] OP_MM  = 3'd7;

   logic [2:0]               st_ff, st_in, op_ff, op_in;
   sums_type                 s_ff, s_in;
   logic [WIDE_W-1:0]        num_ff, num_in, a_ff, a_in, b_ff, b_in;
   logic [DBL_W-1:0]         d_ff, d_in;
   logic [DBL_W:0]           rem_ff, rem_in, shifted;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic [ROOT_W-1:0]        root_ff, root_in, trial;
   logic [2*ROOT_W-1:0]      tsq;
   logic                     zd_ff, zd_in;
   logic                     ov_ff, ov_in;
   logic signed [ROOT_W-1:0] corr_ff, corr_in;
   logic                     zo_ff, zo_in;
   logic [CNT_W-1:0]         len_ff, len_in;
   logic                     mstart, mdone;
   logic [WIDE_W-1:0]        ma, mb, mag, plo, sp;
   logic [DBL_W-1:0]         mprod;
   logic [SUM_W-1:0]         asx, asy;
   logic [SQ_W-1:0]          asxy;
   logic                     neg;
   logic signed [ROOT_W:0]   sres;

   spc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mstart),
      .op_a    (ma),
      .op_b    (mb),
      .done    (mdone),
      .product (mprod)
   );

   always_comb begin
      asx = s_ff.sx[SUM_W-1] ? -s_ff.sx : s_ff.sx;
      asy = s_ff.sy[SUM_W-1] ? -s_ff.sy : s_ff.sy;
      asxy = s_ff.sxy[SQ_W-1] ? -s_ff.sxy : s_ff.sxy;
      neg = num_ff[WIDE_W-1];
      mag = neg ? -num_ff : num_ff;
      case (op_ff)
         OP_NXY: begin ma = WIDE_W'(s_ff.count); mb = WIDE_W'(asxy); end
         OP_XY:  begin ma = WIDE_W'(asx); mb = WIDE_W'(asy); end
         OP_NXX: begin ma = WIDE_W'(s_ff.count); mb = WIDE_W'(s_ff.sxx); end
         OP_XX:  begin ma = WIDE_W'(asx); mb = WIDE_W'(asx); end
         OP_NYY: begin ma = WIDE_W'(s_ff.count); mb = WIDE_W'(s_ff.syy); end
         OP_YY:  begin ma = WIDE_W'(asy); mb = WIDE_W'(asy); end
         OP_AB:  begin ma = a_ff; mb = b_ff; end
         default: begin ma = mag; mb = mag; end
      endcase
      plo = mprod[WIDE_W-1:0];
      case (op_ff)
         OP_NXY: sp = s_ff.sxy[SQ_W-1] ? -plo : plo;
         OP_XY:  sp = (s_ff.sx[SUM_W-1] ^ s_ff.sy[SUM_W-1]) ? -plo : plo;
         default: sp = plo;
      endcase
      shifted = (cnt_ff == 5'd0) ? rem_ff : (rem_ff << 1);
      trial = root_ff | (ROOT_W'(1) << cnt_ff[3:0]);
      tsq = trial * trial;
      sres = neg ? -$signed({1'b0, root_ff}) : $signed({1'b0, root_ff});

      st_in = st_ff;
      op_in = op_ff;
      s_in = s_ff;
      num_in = num_ff;
      a_in = a_ff;
      b_in = b_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      root_in = root_ff;
      zd_in = zd_ff;
      ov_in = ov_ff;
      corr_in = corr_ff;
      zo_in = zo_ff;
      len_in = len_ff;
      q_pop = 1'b0;
      mstart = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               s_in = q_data;
               op_in = OP_NXY;
               zd_in = 1'b0;
               st_in = ST_MST;
            end
         end
         ST_MST: begin
            mstart = 1'b1;
            st_in = ST_MWT;
         end
         ST_MWT: begin
            if (mdone) begin
               op_in = op_ff + 1'b1;
               st_in = ST_MST;
               case (op_ff)
                  OP_NXY: num_in = sp;
                  OP_XY:  num_in = num_ff - sp;
                  OP_NXX: a_in = sp;
                  OP_XX:  a_in = a_ff - sp;
                  OP_NYY: b_in = sp;
                  OP_YY: begin
                     b_in = b_ff - sp;
                     if (a_ff == '0 || b_in == '0) begin
                        zd_in = 1'b1;
                        st_in = ST_OUT;
                     end
                  end
                  OP_AB: d_in = mprod;
                  default: begin
                     rem_in = {1'b0, mprod};
                     quo_in = '0;
                     cnt_in = '0;
                     st_in = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (shifted >= {1'b0, d_ff}) begin
               rem_in = shifted - {1'b0, d_ff};
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(QUO_W - 1)) begin
               root_in = '0;
               cnt_in = 5'(ROOT_W - 1);
               st_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (tsq <= {1'b0, quo_ff}) begin
               root_in = trial;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 5'd0) begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1;
               zo_in = zd_ff;
               len_in = s_ff.count;
               if (zd_ff) begin
                  corr_in = '0;
               end else if (!neg && root_ff > CORR_MAX) begin
                  corr_in = CORR_MAX;
               end else begin
                  corr_in = ROOT_W'(sres);
               end
               if (clamp_negative && (zd_ff || neg || root_ff == '0)) begin
                  corr_in = '0;
               end
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (ov_ff && rsp.ready && !(st_ff == ST_OUT)) begin
         ov_in = 1'b0;
      end
      rsp.valid = ov_ff;
      rsp.correlation = corr_ff;
      rsp.zero_denominator = zo_ff;
      rsp.segment_length = len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
      op_ff <= op_in;
      s_ff <= s_in;
      num_ff <= num_in;
      a_ff <= a_in;
      b_ff <= b_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      root_ff <= root_in;
      zd_ff <= zd_in;
      corr_ff <= corr_in;
      zo_ff <= zo_in;
      len_ff <= len_in;
   end

endmodule
`default_nettype wire
